FILE: sv/lbbt_pkg.sv
// ----------------------------------------------------------------------------
// lbbt_pkg
// Shared types and constants for the LED blink / oneshot / burst timer.
// ----------------------------------------------------------------------------
package lbbt_pkg;

  localparam int OP_W   = 3;
  localparam int DUTY_W = 9;

  // duty_q8 value that means "always on"
  localparam logic [DUTY_W-1:0] DUTY_FULL = 9'd256;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_STEADY  = 3'd1,
    OP_BLINK   = 3'd2,
    OP_ONESHOT = 3'd3,
    OP_BURST   = 3'd4,
    OP_OFF     = 3'd5,
    OP_TOGGLE  = 3'd6
  } op_e;

  // status reported with every result
  typedef struct packed {
    logic led_lit;
    logic pin_level;
    logic busy_res;
    logic pattern_running;
  } flags_t;

endpackage

FILE: sv/lbbt_ireg.sv
// ----------------------------------------------------------------------------
// lbbt_ireg
// Input register: captures one item per transfer and holds it until the
// core consumes it.
// ----------------------------------------------------------------------------
module lbbt_ireg import lbbt_pkg::*; #(
  parameter int PERIOD_BITS = 16,
  parameter int COUNT_BITS  = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [OP_W-1:0]        operation_i,
  input  logic [PERIOD_BITS-1:0] period_ticks_i,
  input  logic [DUTY_W-1:0]      duty_q8_i,
  input  logic [COUNT_BITS-1:0]  pulse_total_i,
  input  logic                   advance_i,
  output logic                   item_valid_o,
  output logic [OP_W-1:0]        operation_o,
  output logic [PERIOD_BITS-1:0] period_ticks_o,
  output logic [DUTY_W-1:0]      duty_q8_o,
  output logic [COUNT_BITS-1:0]  pulse_total_o
);

  logic                   valid_q, valid_d;
  logic                   load;
  logic [OP_W-1:0]        op_q;
  logic [PERIOD_BITS-1:0] period_q;
  logic [DUTY_W-1:0]      duty_q;
  logic [COUNT_BITS-1:0]  total_q;

  // stall only when the held item cannot move on this cycle
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q     <= operation_i;
      period_q <= period_ticks_i;
      duty_q   <= duty_q8_i;
      total_q  <= pulse_total_i;
    end
  end

  assign item_valid_o   = valid_q;
  assign operation_o    = op_q;
  assign period_ticks_o = period_q;
  assign duty_q8_o      = duty_q;
  assign pulse_total_o  = total_q;

endmodule

FILE: sv/lbbt_core.sv
// ----------------------------------------------------------------------------
// lbbt_core
// Pattern state, combinational update per item, and the result register.
// ----------------------------------------------------------------------------
module lbbt_core import lbbt_pkg::*; #(
  parameter int PERIOD_BITS = 16,
  parameter int COUNT_BITS  = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  input  logic [OP_W-1:0]        operation_i,
  input  logic [PERIOD_BITS-1:0] period_ticks_i,
  input  logic [DUTY_W-1:0]      duty_q8_i,
  input  logic [COUNT_BITS-1:0]  pulse_total_i,
  input  logic                   active_high_i,
  output logic                   advance_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output flags_t                 flags_o
);

  localparam int EW = PERIOD_BITS + 1;
  localparam int PW = PERIOD_BITS + DUTY_W;

  logic [EW-1:0]          elapsed_q, elapsed_d;
  logic [PERIOD_BITS-1:0] on_time_q, on_time_d;
  logic [PERIOD_BITS-1:0] off_time_q, off_time_d;
  logic [PERIOD_BITS-1:0] pperiod_q, pperiod_d;
  logic                   locked_q, locked_d;
  logic                   lit_q, lit_d;
  logic                   oneshot_q, oneshot_d;
  logic                   burst_q, burst_d;
  logic [COUNT_BITS-1:0]  pdone_q, pdone_d;
  logic [COUNT_BITS-1:0]  pwant_q, pwant_d;
  logic                   out_valid_q, out_valid_d;
  flags_t                 flags_q, flags_d;

  logic                   consume;
  logic [DUTY_W-1:0]      duty_sat;
  logic [DUTY_W-1:0]      start_duty;
  logic [PW-1:0]          on_sum, off_sum;
  logic [PERIOD_BITS-1:0] on_calc, off_calc;

  assign advance_o = !out_valid_q || !out_stall_i;
  assign consume   = item_valid_i && advance_o;

  // on/off split: ceil(period * frac / 256)
  always_comb begin
    duty_sat   = duty_q8_i[DUTY_W-1] ? DUTY_FULL : duty_q8_i;
    start_duty = (op_e'(operation_i) == OP_ONESHOT) ? DUTY_FULL : duty_sat;
    on_sum     = PW'(period_ticks_i) * PW'(start_duty) + PW'(255);
    off_sum    = PW'(period_ticks_i) * PW'(DUTY_FULL - start_duty) + PW'(255);
    on_calc    = on_sum[PERIOD_BITS+7:8];
    off_calc   = off_sum[PERIOD_BITS+7:8];
  end

  always_comb begin
    logic fin;
    elapsed_d  = elapsed_q;
    on_time_d  = on_time_q;
    off_time_d = off_time_q;
    pperiod_d  = pperiod_q;
    locked_d   = locked_q;
    lit_d      = lit_q;
    oneshot_d  = oneshot_q;
    burst_d    = burst_q;
    pdone_d    = pdone_q;
    pwant_d    = pwant_q;
    fin        = 1'b0;

    case (op_e'(operation_i))
      OP_TICK: begin
        if (!(&elapsed_q)) begin
          elapsed_d = elapsed_q + EW'(1);
        end
        if (pperiod_q != '0 && locked_q) begin
          // on phase ends first; off check sees its outcome
          if (elapsed_d >= EW'(on_time_q) && lit_d) begin
            if (!oneshot_d) begin
              lit_d = 1'b0;
              if (burst_d) begin
                pdone_d = pdone_q + COUNT_BITS'(1);
              end
            end else begin
              oneshot_d = 1'b0;
              if (!burst_d) begin
                locked_d = 1'b0;
                lit_d    = 1'b0;
              end
            end
            elapsed_d = '0;
          end
          if (elapsed_d >= EW'(off_time_q) && !lit_d && !oneshot_d && locked_d) begin
            fin = burst_d && (pdone_d == pwant_q);
            if (!fin) begin
              lit_d     = 1'b1;
              elapsed_d = '0;
            end else begin
              burst_d  = 1'b0;
              locked_d = 1'b0;
              lit_d    = 1'b0;
            end
          end
        end
      end
      OP_STEADY: begin
        if (!locked_q) begin
          pperiod_d = '0;
          locked_d  = 1'b1;
          lit_d     = 1'b1;
          oneshot_d = 1'b0;
          burst_d   = 1'b0;
        end
      end
      OP_BLINK, OP_ONESHOT, OP_BURST: begin
        if (!locked_q) begin
          elapsed_d  = '0;
          pperiod_d  = period_ticks_i;
          on_time_d  = on_calc;
          off_time_d = off_calc;
          locked_d   = 1'b1;
          lit_d      = 1'b1;
          oneshot_d  = (op_e'(operation_i) == OP_ONESHOT);
          burst_d    = (op_e'(operation_i) == OP_BURST);
          if (op_e'(operation_i) == OP_BURST) begin
            pdone_d = '0;
            pwant_d = pulse_total_i;
          end
        end
      end
      OP_OFF: begin
        if (!oneshot_q && !burst_q) begin
          locked_d = 1'b0;
          lit_d    = 1'b0;
        end
      end
      OP_TOGGLE: begin
        lit_d = !lit_q;
      end
      default: begin
      end
    endcase

    flags_d.led_lit         = lit_d;
    flags_d.pin_level       = active_high_i ? lit_d : !lit_d;
    flags_d.busy_res        = locked_d;
    flags_d.pattern_running = oneshot_d || burst_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance_o) begin
      out_valid_d = item_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q   <= '0;
      on_time_q   <= '0;
      off_time_q  <= '0;
      pperiod_q   <= '0;
      locked_q    <= 1'b0;
      lit_q       <= 1'b0;
      oneshot_q   <= 1'b0;
      burst_q     <= 1'b0;
      pdone_q     <= '0;
      pwant_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (consume) begin
        elapsed_q  <= elapsed_d;
        on_time_q  <= on_time_d;
        off_time_q <= off_time_d;
        pperiod_q  <= pperiod_d;
        locked_q   <= locked_d;
        lit_q      <= lit_d;
        oneshot_q  <= oneshot_d;
        burst_q    <= burst_d;
        pdone_q    <= pdone_d;
        pwant_q    <= pwant_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      flags_q <= flags_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign flags_o     = flags_q;

endmodule

FILE: sv/led_blink_burst_timer.sv
// ----------------------------------------------------------------------------
// led_blink_burst_timer
// LED driver for steady, blink, oneshot and burst patterns, timed by ticks.
// ----------------------------------------------------------------------------
// Takes one tick or command per clock while out_stall_i is low and returns one
// status result per item. An item passes an input register and then the
// result register; throughput is one item per cycle while out_stall_i is low,
// set by the combinational state update in lbbt_core (saturating elapsed
// count, on/off compares and the period*duty products for a start command).
// The polarity register is written through the cfg channel, which is always
// ready; write it only while no item is in flight.
module led_blink_burst_timer import lbbt_pkg::*; #(
  parameter int PERIOD_BITS = 16,
  parameter int COUNT_BITS  = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [OP_W-1:0]        operation_i,
  input  logic [PERIOD_BITS-1:0] period_ticks_i,
  input  logic [DUTY_W-1:0]      duty_q8_i,
  input  logic [COUNT_BITS-1:0]  pulse_total_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   led_lit_o,
  output logic                   pin_level_o,
  output logic                   busy_res_o,
  output logic                   pattern_running_o
);

  logic                   active_high_q;
  logic                   advance;
  logic                   item_valid;
  logic [OP_W-1:0]        item_op;
  logic [PERIOD_BITS-1:0] item_period;
  logic [DUTY_W-1:0]      item_duty;
  logic [COUNT_BITS-1:0]  item_total;
  flags_t                 flags;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_high_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_high_q <= cfg_data_i;
    end
  end

  lbbt_ireg #(
    .PERIOD_BITS (PERIOD_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_ireg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .period_ticks_i (period_ticks_i),
    .duty_q8_i      (duty_q8_i),
    .pulse_total_i  (pulse_total_i),
    .advance_i      (advance),
    .item_valid_o   (item_valid),
    .operation_o    (item_op),
    .period_ticks_o (item_period),
    .duty_q8_o      (item_duty),
    .pulse_total_o  (item_total)
  );

  lbbt_core #(
    .PERIOD_BITS (PERIOD_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .operation_i    (item_op),
    .period_ticks_i (item_period),
    .duty_q8_i      (item_duty),
    .pulse_total_i  (item_total),
    .active_high_i  (active_high_q),
    .advance_o      (advance),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .flags_o        (flags)
  );

  assign led_lit_o         = flags.led_lit;
  assign pin_level_o       = flags.pin_level;
  assign busy_res_o        = flags.busy_res;
  assign pattern_running_o = flags.pattern_running;

endmodule

FILE: test/led_status_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_status_checker
// Predicts the LED status after every accepted item and checks each result.
// ----------------------------------------------------------------------------
// Watches the polarity write channel and both item channels of the timer.
// Every input transfer runs through a copy of the timer state and queues the
// status it should report; every output transfer is compared, field by field,
// with the oldest queued status. The number of queued statuses and the
// predicted pattern-running flag are handed back to the stimulus side.
module led_status_checker import lbbt_pkg::*; #(
  parameter int PERIOD_BITS = 16,
  parameter int COUNT_BITS  = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic                   cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [OP_W-1:0]        operation_i,
  input  logic [PERIOD_BITS-1:0] period_ticks_i,
  input  logic [DUTY_W-1:0]      duty_q8_i,
  input  logic [COUNT_BITS-1:0]  pulse_total_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic                   led_lit_i,
  input  logic                   pin_level_i,
  input  logic                   busy_res_i,
  input  logic                   pattern_running_i,
  output int                     mismatches_o,
  output int                     outstanding_o,
  output logic                   running_o
);

  logic [PERIOD_BITS:0]   elapsed_q;
  logic [PERIOD_BITS-1:0] on_len;
  logic [PERIOD_BITS-1:0] off_len;
  logic [PERIOD_BITS-1:0] cycle_len;
  logic [COUNT_BITS-1:0]  pulses_done;
  logic [COUNT_BITS-1:0]  pulses_goal;
  logic                   locked;
  logic                   lit;
  logic                   oneshot_on;
  logic                   burst_on;
  logic                   polarity;
  flags_t                 expected_status[$];
  int                     mismatches = 0;

  assign mismatches_o = mismatches;

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_flag(string name, logic got, logic want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0b, expected %0b", name, got, want));
    end
  endtask

  // ceil(span * frac / 256), kept at the period width
  function automatic logic [PERIOD_BITS-1:0] share_of(logic [PERIOD_BITS-1:0] span,
                                                      logic [DUTY_W-1:0] frac);
    logic [PERIOD_BITS+DUTY_W:0] prod;
    prod = span * frac + (PERIOD_BITS+DUTY_W+1)'(255);
    return prod[PERIOD_BITS+7:8];
  endfunction

  task automatic start_pattern(logic [PERIOD_BITS-1:0] span, logic [DUTY_W-1:0] duty,
                               logic one, logic brst);
    logic [DUTY_W-1:0] d;
    d = (duty > DUTY_FULL) ? DUTY_FULL : duty;
    elapsed_q = '0;
    cycle_len = span;
    if (one) begin
      on_len  = span;
      off_len = '0;
    end else begin
      on_len  = share_of(span, d);
      off_len = share_of(span, DUTY_FULL - d);
    end
    locked     = 1'b1;
    lit        = 1'b1;
    oneshot_on = one;
    burst_on   = brst;
  endtask

  task automatic advance_led_state(logic [OP_W-1:0] op, logic [PERIOD_BITS-1:0] span,
                                   logic [DUTY_W-1:0] duty, logic [COUNT_BITS-1:0] total);
    case (op)
      OP_TICK: begin
        if (elapsed_q != '1) elapsed_q++;
        if (cycle_len != '0 && locked) begin
          // off check runs after the on check and sees its outcome
          if (elapsed_q >= on_len && lit) begin
            if (!oneshot_on) begin
              lit = 1'b0;
              if (burst_on) pulses_done++;
            end else begin
              oneshot_on = 1'b0;
              if (!burst_on) begin
                locked = 1'b0;
                lit    = 1'b0;
              end
            end
            elapsed_q = '0;
          end
          if (elapsed_q >= off_len && !lit && !oneshot_on && locked) begin
            if (!(burst_on && pulses_done == pulses_goal)) begin
              lit       = 1'b1;
              elapsed_q = '0;
            end else begin
              burst_on = 1'b0;
              locked   = 1'b0;
              lit      = 1'b0;
            end
          end
        end
      end
      OP_STEADY: begin
        if (!locked) begin
          cycle_len  = '0;
          locked     = 1'b1;
          lit        = 1'b1;
          oneshot_on = 1'b0;
          burst_on   = 1'b0;
        end
      end
      OP_BLINK:   if (!locked) start_pattern(span, duty, 1'b0, 1'b0);
      OP_ONESHOT: if (!locked) start_pattern(span, DUTY_FULL, 1'b1, 1'b0);
      OP_BURST: begin
        if (!locked) begin
          start_pattern(span, duty, 1'b0, 1'b1);
          pulses_done = '0;
          pulses_goal = total;
        end
      end
      OP_OFF: begin
        if (!oneshot_on && !burst_on) begin
          locked = 1'b0;
          lit    = 1'b0;
        end
      end
      OP_TOGGLE: lit = !lit;
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    flags_t want;
    flags_t now;
    if (!rst_ni) begin
      elapsed_q   = '0;
      on_len      = '0;
      off_len     = '0;
      cycle_len   = '0;
      pulses_done = '0;
      pulses_goal = '0;
      locked      = 1'b0;
      lit         = 1'b0;
      oneshot_on  = 1'b0;
      burst_on    = 1'b0;
      polarity    = 1'b1;
      expected_status.delete();
      outstanding_o <= 0;
      running_o     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) polarity = cfg_data_i;

      if (out_valid_i && !out_stall_i) begin
        if (expected_status.size() == 0) begin
          report_mismatch("result transfer with no item pending");
        end else begin
          want = expected_status.pop_front();
          check_flag("led_lit", led_lit_i, want.led_lit);
          check_flag("pin_level", pin_level_i, want.pin_level);
          check_flag("busy_res", busy_res_i, want.busy_res);
          check_flag("pattern_running", pattern_running_i, want.pattern_running);
        end
      end

      if (in_valid_i && !in_stall_i) begin
        advance_led_state(operation_i, period_ticks_i, duty_q8_i, pulse_total_i);
        now.led_lit         = lit;
        now.pin_level       = polarity ? lit : !lit;
        now.busy_res        = locked;
        now.pattern_running = oneshot_on || burst_on;
        expected_status.push_back(now);
      end

      outstanding_o <= expected_status.size();
      running_o     <= oneshot_on || burst_on;
    end
  end

endmodule

FILE: test/led_blink_burst_timer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_blink_burst_timer_tb
// Directed and random item streams for the LED blink / burst timer.
// ----------------------------------------------------------------------------
// A short directed part walks every command, the lock and pattern rules,
// full and oversized duty, the widest period and the unused opcode. Random
// episodes then start blinks, oneshots and bursts and tick them out with
// toggles, ignored commands and stray offs mixed in. A zero-count burst is
// run to its wrap, and the run ends in a zero-length oneshot, which holds the
// lock for good. Polarity is rewritten between phases while the timer is
// idle. Both channels idle at random; a checker instance does all checking.
module led_blink_burst_timer_tb;
  import lbbt_pkg::*;

  localparam int PERIOD_BITS = 16;
  localparam int COUNT_BITS  = 8;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic                   cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [OP_W-1:0]        operation_i;
  logic [PERIOD_BITS-1:0] period_ticks_i;
  logic [DUTY_W-1:0]      duty_q8_i;
  logic [COUNT_BITS-1:0]  pulse_total_i;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic                   led_lit_o;
  logic                   pin_level_o;
  logic                   busy_res_o;
  logic                   pattern_running_o;

  int   mismatches;
  int   outstanding;
  logic pattern_live;
  int   gap_pct   = 17;
  int   hold_pct  = 17;
  int   items_sent = 0;

  led_blink_burst_timer #(
    .PERIOD_BITS(PERIOD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .period_ticks_i   (period_ticks_i),
    .duty_q8_i        (duty_q8_i),
    .pulse_total_i    (pulse_total_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .led_lit_o        (led_lit_o),
    .pin_level_o      (pin_level_o),
    .busy_res_o       (busy_res_o),
    .pattern_running_o(pattern_running_o)
  );

  led_status_checker #(
    .PERIOD_BITS(PERIOD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .operation_i      (operation_i),
    .period_ticks_i   (period_ticks_i),
    .duty_q8_i        (duty_q8_i),
    .pulse_total_i    (pulse_total_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .led_lit_i        (led_lit_o),
    .pin_level_i      (pin_level_o),
    .busy_res_i       (busy_res_o),
    .pattern_running_i(pattern_running_o),
    .mismatches_o     (mismatches),
    .outstanding_o    (outstanding),
    .running_o        (pattern_live)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < hold_pct);
  end

  initial begin
    #500000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [DUTY_W-1:0] rand_duty();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return '0;
    if (pick < 4) return DUTY_FULL;
    if (pick < 6) return DUTY_W'($urandom_range(257, 511));
    return DUTY_W'($urandom_range(0, 256));
  endfunction

  function automatic logic [PERIOD_BITS-1:0] rand_period();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return PERIOD_BITS'($urandom);
    return PERIOD_BITS'($urandom_range(1, 12));
  endfunction

  // hold the item until its transfer; valid stays high for the next item
  task automatic send_item(logic [OP_W-1:0] op, logic [PERIOD_BITS-1:0] span,
                           logic [DUTY_W-1:0] duty, logic [COUNT_BITS-1:0] total);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    period_ticks_i <= span;
    duty_q8_i      <= duty;
    pulse_total_i  <= total;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic send_plain(logic [OP_W-1:0] op);
    send_item(op, PERIOD_BITS'($urandom), DUTY_W'($urandom_range(0, 511)),
              COUNT_BITS'($urandom));
  endtask

  // mostly ticks, with toggles, offs, the unused opcode and short starts
  task automatic send_mixed();
    int  pick;
    op_e start_op;
    pick = $urandom_range(0, 99);
    if (pick < 75) send_plain(OP_TICK);
    else if (pick < 83) send_plain(OP_TOGGLE);
    else if (pick < 89) send_plain(OP_OFF);
    else if (pick < 92) send_plain(OP_UNUSED);
    else begin
      start_op = op_e'($urandom_range(OP_STEADY, OP_BURST));
      if (start_op == OP_ONESHOT || start_op == OP_BURST) begin
        send_item(start_op, PERIOD_BITS'($urandom_range(1, 8)), rand_duty(),
                  COUNT_BITS'($urandom_range(1, 4)));
      end else begin
        send_plain(start_op);
      end
    end
  endtask

  // pattern_live lags one transfer behind, so always send at least one item
  task automatic run_out_pattern(int cap, bit noisy);
    int n;
    n = 0;
    do begin
      if (noisy) send_mixed();
      else send_plain(OP_TICK);
      n++;
    end while (pattern_live && n < cap);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_polarity(logic level);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= level;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_episode();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_item(OP_BLINK, rand_period(), rand_duty(), COUNT_BITS'($urandom));
      repeat ($urandom_range(3, 25)) send_mixed();
    end else if (pick < 50) begin
      send_item(OP_ONESHOT, PERIOD_BITS'($urandom_range(1, 12)), rand_duty(),
                COUNT_BITS'($urandom));
    end else if (pick < 75) begin
      send_item(OP_BURST, PERIOD_BITS'($urandom_range(1, 10)), rand_duty(),
                COUNT_BITS'($urandom_range(1, 6)));
    end else if (pick < 85) begin
      send_plain(OP_STEADY);
      repeat ($urandom_range(2, 10)) send_mixed();
    end else begin
      repeat ($urandom_range(2, 8)) send_mixed();
    end
    run_out_pattern(3000, 1'b1);
    send_plain(OP_OFF);
  endtask

  initial begin
    int target;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = 1'b0;
    in_valid_i     = 1'b0;
    operation_i    = OP_TICK;
    period_ticks_i = '0;
    duty_q8_i      = '0;
    pulse_total_i  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset polarity
    send_plain(OP_TICK);
    send_plain(OP_TOGGLE);
    send_plain(OP_OFF);
    send_plain(OP_UNUSED);
    send_item(OP_STEADY, '0, '0, '0);
    send_item(OP_BLINK, '1, '1, '1);
    send_item(OP_ONESHOT, 16'd5, '0, '0);
    send_item(OP_BURST, 16'd5, 9'd128, 8'd3);
    send_plain(OP_TICK);
    send_plain(OP_OFF);
    send_item(OP_BLINK, '0, 9'd128, '0);
    send_plain(OP_TICK);
    send_plain(OP_OFF);
    send_item(OP_BLINK, '1, '1, '0);
    send_plain(OP_TICK);
    send_plain(OP_TOGGLE);
    send_plain(OP_TICK);
    send_plain(OP_OFF);
    send_item(OP_BLINK, 16'd3, '0, '0);
    repeat (4) send_plain(OP_TICK);
    send_plain(OP_OFF);
    send_item(OP_ONESHOT, 16'd2, DUTY_FULL, '0);
    send_plain(OP_OFF);
    run_out_pattern(100, 1'b0);
    send_item(OP_BURST, 16'd2, 9'd128, 8'd2);
    run_out_pattern(100, 1'b0);
    send_plain(OP_OFF);

    wait_for_results();
    set_polarity(1'b0);
    target = items_sent + 50;
    while (items_sent < target) run_episode();

    // zero count wraps to a full 2^COUNT_BITS pulses, one tick each; no idling
    wait_for_results();
    set_polarity(1'b1);
    gap_pct  = 0;
    hold_pct = 0;
    send_item(OP_BURST, 16'd1, DUTY_FULL, '0);
    run_out_pattern(2000, 1'b0);
    send_plain(OP_OFF);
    gap_pct  = 17;
    hold_pct = 17;

    target = items_sent + 50;
    while (items_sent < target) run_episode();

    // a zero-length oneshot never ends; the lock holds to the end of the run
    wait_for_results();
    set_polarity(1'b0);
    send_item(OP_ONESHOT, '0, DUTY_FULL, '0);
    send_plain(OP_TICK);
    send_plain(OP_OFF);
    send_plain(OP_TOGGLE);
    send_plain(OP_BLINK);
    send_plain(OP_BURST);
    send_plain(OP_UNUSED);
    send_plain(OP_TICK);
    wait_for_results();
    set_polarity(1'b1);
    send_plain(OP_TOGGLE);
    send_plain(OP_TICK);
    send_plain(OP_OFF);

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: led_blink_burst_timer.f
sv/lbbt_pkg.sv
sv/lbbt_ireg.sv
sv/lbbt_core.sv
sv/led_blink_burst_timer.sv
test/led_status_checker.sv
test/led_blink_burst_timer_tb.sv
